### hw/rtl/spc_pkg.sv
// ============================================================================
// spc_pkg: shared definitions of the shutter panel controller
// Command codes, register indexes, reset values and the structs that pass
// configuration, command decode and status between the modules.
// ============================================================================
package spc_pkg;

    // Command codes in bits 6:4 of a command byte.
    typedef enum logic [2:0] {
        CMD_NOP        = 3'd0,
        CMD_LOAD_BEEP  = 3'd1,
        CMD_BLOCK_MODE = 3'd2,
        CMD_QUERY_SW   = 3'd3,
        CMD_INTERRUPT  = 3'd4,
        CMD_BLOCK_SW   = 3'd5,
        CMD_SPARE6     = 3'd6,
        CMD_SPARE7     = 3'd7
    } t_cmd;

    // Block LED modes.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_SLOW = 2'd1;
    localparam logic [1:0] MODE_FAST = 2'd2;
    localparam logic [1:0] MODE_ON   = 2'd3;

    // Reply codes.
    localparam logic [7:0] REPLY_ERR     = 8'd0;
    localparam logic [7:0] REPLY_OK      = 8'd1;
    localparam logic [7:0] REPLY_UP      = 8'd1;
    localparam logic [7:0] REPLY_DOWN    = 8'd2;
    localparam logic [7:0] REPLY_NEITHER = 8'd3;
    localparam logic [7:0] REPLY_SW_ON   = 8'd1;
    localparam logic [7:0] REPLY_SW_OFF  = 8'd2;

    // Data values of the block switch command.
    localparam logic [3:0] BSW_DATA_CLEAR = 4'd1;
    localparam logic [3:0] BSW_DATA_SET   = 4'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_SLOW_BLINK = 2'd1;
    localparam logic [1:0] REG_FAST_BLINK = 2'd2;
    localparam logic [1:0] REG_BEEP_STEP  = 2'd3;

    localparam logic [7:0]  DEBOUNCE_RST   = 8'd50;
    localparam logic [15:0] SLOW_BLINK_RST = 16'd3000;
    localparam logic [15:0] FAST_BLINK_RST = 16'd1000;
    localparam logic [7:0]  BEEP_STEP_RST  = 8'd250;

    typedef struct packed {
        logic [7:0]  debounce;
        logic [15:0] slow_blink;
        logic [15:0] fast_blink;
        logic [7:0]  beep_step;
    } t_cfg;

    // State changes requested by one command byte, plus its reply.
    typedef struct packed {
        logic       beep_load;
        logic       mode_load;
        logic       evt_set;
        logic       evt_clear;
        logic       bsw_clear;
        logic       bsw_set;
        logic [7:0] reply;
    } t_cmd_upd;

    // Output levels after an item has been applied.
    typedef struct packed {
        logic block_led;
        logic red_led;
        logic green_led;
        logic beeper;
        logic int_drive_low;
    } t_status;

endpackage

### hw/rtl/spc_cmd.sv
// ============================================================================
// spc_cmd: command byte decoder
// Checks the even parity, decodes the command code and produces the reply
// together with the state changes that the command asks for.
// ============================================================================
module spc_cmd (
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_reported_switches,
    input  logic              i_block_switch_on,
    output spc_pkg::t_cmd_upd o_upd
);

    logic              parity_ok;
    spc_pkg::t_cmd     cmd;
    logic [3:0]        data;
    logic              sw_up;
    logic              sw_dn;
    logic              sw_valid;

    assign parity_ok = (i_byte[7] == ^i_byte[6:0]);
    assign cmd       = spc_pkg::t_cmd'(i_byte[6:4]);
    assign data      = i_byte[3:0];

    // Each switch has an up and a down bit in the reported byte.
    always_comb begin
        sw_valid = 1'b1;
        sw_up    = 1'b0;
        sw_dn    = 1'b0;
        case (data)
            4'd1: begin
                sw_up = i_reported_switches[4];
                sw_dn = i_reported_switches[3];
            end
            4'd2: begin
                sw_up = i_reported_switches[5];
                sw_dn = i_reported_switches[2];
            end
            4'd3: begin
                sw_up = i_reported_switches[6];
                sw_dn = i_reported_switches[1];
            end
            4'd4: begin
                sw_up = i_reported_switches[0];
                sw_dn = i_reported_switches[7];
            end
            default: begin
                sw_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_upd = '0;
        o_upd.reply = spc_pkg::REPLY_ERR;
        if (parity_ok) begin
            case (cmd)
                spc_pkg::CMD_LOAD_BEEP: begin
                    o_upd.beep_load = 1'b1;
                    o_upd.reply     = spc_pkg::REPLY_OK;
                end
                spc_pkg::CMD_BLOCK_MODE: begin
                    o_upd.mode_load = 1'b1;
                    o_upd.reply     = spc_pkg::REPLY_OK;
                end
                spc_pkg::CMD_QUERY_SW: begin
                    if (!sw_valid) begin
                        o_upd.reply = spc_pkg::REPLY_ERR;
                    end else if (sw_up) begin
                        o_upd.reply = spc_pkg::REPLY_UP;
                    end else if (sw_dn) begin
                        o_upd.reply = spc_pkg::REPLY_DOWN;
                    end else begin
                        o_upd.reply = spc_pkg::REPLY_NEITHER;
                    end
                end
                spc_pkg::CMD_INTERRUPT: begin
                    o_upd.evt_set   = (data != 4'd0);
                    o_upd.evt_clear = (data == 4'd0);
                    o_upd.reply     = spc_pkg::REPLY_OK;
                end
                spc_pkg::CMD_BLOCK_SW: begin
                    o_upd.reply     = i_block_switch_on ? spc_pkg::REPLY_SW_ON
                                                        : spc_pkg::REPLY_SW_OFF;
                    o_upd.bsw_clear = (data == spc_pkg::BSW_DATA_CLEAR);
                    o_upd.bsw_set   = (data == spc_pkg::BSW_DATA_SET);
                end
                default: begin
                    o_upd.reply = spc_pkg::REPLY_ERR;
                end
            endcase
        end
    end

endmodule

### hw/rtl/spc_core.sv
// ============================================================================
// spc_core: panel state and tick processing
// Holds the panel state, applies one tick or one decoded command per enabled
// cycle and presents the output levels that follow from the new state.
// ============================================================================
module spc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_opcode,
    input  logic [7:0]        i_command_byte,
    input  logic              i_key_level,
    input  logic [7:0]        i_switch_raw,
    input  logic              i_int_line_level,
    input  spc_pkg::t_cfg     i_cfg,
    output logic [7:0]        o_reply,
    output spc_pkg::t_status  o_status
);

    logic        r_flag_block_event, n_flag_block_event;
    logic        r_flag_switch_event, n_flag_switch_event;
    logic        r_flag_beep_on, n_flag_beep_on;
    logic        r_flag_red, n_flag_red;
    logic        r_flag_green, n_flag_green;
    logic [1:0]  r_block_mode, n_block_mode;
    logic        r_block_switch_on, n_block_switch_on;
    logic [7:0]  r_reported_switches, n_reported_switches;
    logic        r_key_stable, n_key_stable;
    logic [7:0]  r_key_count, n_key_count;
    logic [7:0]  r_switch_stable, n_switch_stable;
    logic [7:0]  r_switch_count, n_switch_count;
    logic [15:0] r_blink_count, n_blink_count;
    logic [7:0]  r_beep_count, n_beep_count;
    logic [3:0]  r_beep_bits, n_beep_bits;
    logic        r_block_led, n_block_led;
    logic        r_beeper, n_beeper;

    spc_pkg::t_cmd_upd cmd_upd;

    logic        pressed;
    logic [7:0]  key_dec;
    logic [7:0]  sw_dec;
    logic        key_released;
    logic [15:0] blink_dec;
    logic [7:0]  beep_dec;

    spc_cmd u_cmd (
        .i_byte              (i_command_byte),
        .i_reported_switches (r_reported_switches),
        .i_block_switch_on   (r_block_switch_on),
        .o_upd               (cmd_upd)
    );

    assign pressed   = ~i_key_level;
    assign key_dec   = r_key_count - 8'd1;
    assign sw_dec    = r_switch_count - 8'd1;
    assign blink_dec = (r_blink_count != 16'd0) ? r_blink_count - 16'd1 : 16'd0;
    assign beep_dec  = (r_beep_count != 8'd0) ? r_beep_count - 8'd1 : 8'd0;

    always_comb begin
        n_flag_block_event  = r_flag_block_event;
        n_flag_switch_event = r_flag_switch_event;
        n_flag_beep_on      = r_flag_beep_on;
        n_flag_red          = r_flag_red;
        n_flag_green        = r_flag_green;
        n_block_mode        = r_block_mode;
        n_block_switch_on   = r_block_switch_on;
        n_reported_switches = r_reported_switches;
        n_key_stable        = r_key_stable;
        n_key_count         = r_key_count;
        n_switch_stable     = r_switch_stable;
        n_switch_count      = r_switch_count;
        n_blink_count       = r_blink_count;
        n_beep_count        = r_beep_count;
        n_beep_bits         = r_beep_bits;
        n_block_led         = r_block_led;
        n_beeper            = r_beeper;
        key_released        = 1'b0;

        if (i_opcode) begin
            if (cmd_upd.beep_load) begin
                n_beep_bits = i_command_byte[3:0];
            end
            if (cmd_upd.mode_load) begin
                n_block_mode = i_command_byte[1:0];
            end
            if (cmd_upd.evt_set) begin
                n_flag_block_event = 1'b1;
            end
            if (cmd_upd.evt_clear) begin
                n_flag_block_event  = 1'b0;
                n_flag_switch_event = 1'b0;
            end
            if (cmd_upd.bsw_clear) begin
                n_block_switch_on = 1'b0;
            end
            if (cmd_upd.bsw_set) begin
                n_block_switch_on = 1'b1;
            end
        end else begin
            // Key debounce. A release is consumed in the same tick, so no
            // pending-release flag needs to survive between items.
            if (pressed != r_key_stable) begin
                if (key_dec == 8'd0) begin
                    n_key_count  = i_cfg.debounce;
                    n_key_stable = pressed;
                    key_released = ~pressed;
                end else begin
                    n_key_count = key_dec;
                end
            end else begin
                n_key_count = i_cfg.debounce;
            end

            if (i_switch_raw != r_switch_stable) begin
                if (sw_dec == 8'd0) begin
                    n_switch_count  = i_cfg.debounce;
                    n_switch_stable = i_switch_raw;
                end else begin
                    n_switch_count = sw_dec;
                end
            end else begin
                n_switch_count = i_cfg.debounce;
            end

            if (key_released) begin
                n_flag_block_event = 1'b1;
                n_block_switch_on  = ~r_block_switch_on;
            end
            if (n_switch_stable != r_reported_switches) begin
                n_reported_switches = n_switch_stable;
                n_flag_switch_event = 1'b1;
            end
            n_flag_red   = ~i_int_line_level;
            n_flag_green = ~(n_flag_block_event | n_flag_switch_event);

            case (r_block_mode)
                spc_pkg::MODE_OFF: begin
                    n_block_led = 1'b0;
                end
                spc_pkg::MODE_ON: begin
                    n_block_led = 1'b1;
                end
                default: begin
                    if (blink_dec == 16'd0) begin
                        n_block_led   = ~r_block_led;
                        n_blink_count = (r_block_mode == spc_pkg::MODE_SLOW)
                                        ? i_cfg.slow_blink : i_cfg.fast_blink;
                    end else begin
                        n_blink_count = blink_dec;
                    end
                end
            endcase

            // Beep: each pattern bit lasts one step; while on, the tone
            // toggles on every tick with an odd count.
            if ((r_beep_bits != 4'd0) || r_flag_beep_on) begin
                if (beep_dec == 8'd0) begin
                    n_flag_beep_on = r_beep_bits[0];
                    if (!r_beep_bits[0]) begin
                        n_beeper = 1'b0;
                    end
                    n_beep_bits  = r_beep_bits >> 1;
                    n_beep_count = i_cfg.beep_step;
                end else begin
                    n_beep_count = beep_dec;
                end
                if (n_beep_count[0] && n_flag_beep_on) begin
                    n_beeper = ~n_beeper;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_block_event  <= 1'b0;
            r_flag_switch_event <= 1'b0;
            r_flag_beep_on      <= 1'b0;
            r_flag_red          <= 1'b0;
            r_flag_green        <= 1'b0;
            r_block_mode        <= spc_pkg::MODE_OFF;
            r_block_switch_on   <= 1'b0;
            r_reported_switches <= 8'd0;
            r_key_stable        <= 1'b0;
            r_key_count         <= spc_pkg::DEBOUNCE_RST;
            r_switch_stable     <= 8'd0;
            r_switch_count      <= spc_pkg::DEBOUNCE_RST;
            r_blink_count       <= 16'd0;
            r_beep_count        <= 8'd0;
            r_beep_bits         <= 4'd0;
            r_block_led         <= 1'b0;
            r_beeper            <= 1'b0;
        end else if (i_en) begin
            r_flag_block_event  <= n_flag_block_event;
            r_flag_switch_event <= n_flag_switch_event;
            r_flag_beep_on      <= n_flag_beep_on;
            r_flag_red          <= n_flag_red;
            r_flag_green        <= n_flag_green;
            r_block_mode        <= n_block_mode;
            r_block_switch_on   <= n_block_switch_on;
            r_reported_switches <= n_reported_switches;
            r_key_stable        <= n_key_stable;
            r_key_count         <= n_key_count;
            r_switch_stable     <= n_switch_stable;
            r_switch_count      <= n_switch_count;
            r_blink_count       <= n_blink_count;
            r_beep_count        <= n_beep_count;
            r_beep_bits         <= n_beep_bits;
            r_block_led         <= n_block_led;
            r_beeper            <= n_beeper;
        end
    end

    assign o_reply                = i_opcode ? cmd_upd.reply : 8'd0;
    assign o_status.block_led     = n_block_led;
    assign o_status.red_led       = n_flag_red;
    assign o_status.green_led     = n_flag_green;
    assign o_status.beeper        = n_beeper;
    assign o_status.int_drive_low = n_flag_block_event | n_flag_switch_event;

endmodule

### hw/rtl/shutter_panel_controller_top.sv
// ============================================================================
// shutter_panel_controller_top: shutter panel controller
// Takes timer ticks and bus command bytes, keeps the panel state and returns
// one result beat per input beat with reply, LED, beeper and interrupt levels.
// ============================================================================
//
//   Channel  Direction  Handshake                   Payload
//   -------  ---------  --------------------------  ---------------------------
//   in       sink       i_in_valid / o_in_stall     opcode, command byte, key,
//                                                   switch byte, line level
//   out      source     o_out_valid / i_out_stall   reply, check byte, LEDs,
//                                                   beeper, interrupt drive
//   cfg      sink       i_cfg_we (no wait)          index, 16-bit data
//
// A beat accepted at one edge waits in the input register and goes through the
// state update into the result register when that register is empty or its
// beat is being taken.
// One beat is accepted per cycle when the output side keeps up; the rate is
// set by the single update of the panel state, which runs once per cycle.
// Reset is synchronous and active low; it clears the state, the beat valid
// flags and returns the configuration registers to their default values.
// When the output stalls, the result register holds, the input register
// keeps its beat and o_in_stall rises only if that register is occupied.
//
module shutter_panel_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_command_byte,
    input  logic        i_key_level,
    input  logic [7:0]  i_switch_raw,
    input  logic        i_int_line_level,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_reply,
    output logic [7:0]  o_reply,
    output logic [7:0]  o_reply_inverse,
    output logic        o_block_led,
    output logic        o_red_led,
    output logic        o_green_led,
    output logic        o_beeper,
    output logic        o_int_drive_low,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers.
    spc_pkg::t_cfg r_cfg;

    // Input register: one beat waiting for the state update.
    logic       r_in_vld;
    logic       r_opcode;
    logic [7:0] r_command_byte;
    logic       r_key_level;
    logic [7:0] r_switch_raw;
    logic       r_int_line_level;

    // Result register.
    logic             r_out_vld;
    logic             r_is_reply;
    logic [7:0]       r_reply;
    logic [7:0]       r_reply_inverse;
    spc_pkg::t_status r_status;

    logic             advance;
    logic             in_take;
    logic [7:0]       core_reply;
    spc_pkg::t_status core_status;

    // The beat in the input register moves on when the result register is
    // empty or its beat is being taken this cycle.
    assign advance    = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_in_vld & ~advance;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce   <= spc_pkg::DEBOUNCE_RST;
            r_cfg.slow_blink <= spc_pkg::SLOW_BLINK_RST;
            r_cfg.fast_blink <= spc_pkg::FAST_BLINK_RST;
            r_cfg.beep_step  <= spc_pkg::BEEP_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spc_pkg::REG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data[7:0];
                spc_pkg::REG_SLOW_BLINK: r_cfg.slow_blink <= i_cfg_data;
                spc_pkg::REG_FAST_BLINK: r_cfg.fast_blink <= i_cfg_data;
                spc_pkg::REG_BEEP_STEP:  r_cfg.beep_step  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode         <= i_opcode;
            r_command_byte   <= i_command_byte;
            r_key_level      <= i_key_level;
            r_switch_raw     <= i_switch_raw;
            r_int_line_level <= i_int_line_level;
        end
    end

    spc_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (advance),
        .i_opcode         (r_opcode),
        .i_command_byte   (r_command_byte),
        .i_key_level      (r_key_level),
        .i_switch_raw     (r_switch_raw),
        .i_int_line_level (r_int_line_level),
        .i_cfg            (r_cfg),
        .o_reply          (core_reply),
        .o_status         (core_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Ticks carry a zero reply and a zero check byte.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_is_reply      <= r_opcode;
            r_reply         <= core_reply;
            r_reply_inverse <= r_opcode ? ~core_reply : 8'd0;
            r_status        <= core_status;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_is_reply      = r_is_reply;
    assign o_reply         = r_reply;
    assign o_reply_inverse = r_reply_inverse;
    assign o_block_led     = r_status.block_led;
    assign o_red_led       = r_status.red_led;
    assign o_green_led     = r_status.green_led;
    assign o_beeper        = r_status.beeper;
    assign o_int_drive_low = r_status.int_drive_low;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench of the shutter panel controller
// Feeds timer ticks and command bytes through the input channel, predicts
// each result beat with a model of the panel state kept here, and compares
// the result channel field by field. The run steps through several register
// settings, with random idle bursts on both channels.
// ============================================================================
module tb;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // The slowest correct run is about 1600 beats, each waiting out the longest
    // sender gap and the longest receiver stall, plus one long hold and the drain
    // between phases. That is well under CYCLE_LIMIT.
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int LONG_HOLD_AFTER  = 400;
    localparam int PHASES           = 9;
    localparam int PRINT_LIMIT      = 40;

    typedef struct packed {
        logic       opcode;
        logic [7:0] cmd_byte;
        logic       key_level;
        logic [7:0] switch_raw;
        logic       line_level;
    } t_beat;

    typedef struct packed {
        logic       is_reply;
        logic [7:0] reply;
        logic [7:0] reply_inv;
        logic       block_led;
        logic       red_led;
        logic       green_led;
        logic       beeper;
        logic       int_low;
    } t_result;

    // Every input has a known value from time zero.
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        i_opcode         = 1'b0;
    logic [7:0]  i_command_byte   = 8'd0;
    logic        i_key_level      = 1'b1;
    logic [7:0]  i_switch_raw     = 8'd0;
    logic        i_int_line_level = 1'b1;
    logic        i_out_stall      = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_index      = spc_pkg::REG_DEBOUNCE;
    logic [15:0] i_cfg_data       = 16'd0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_is_reply;
    logic [7:0]  o_reply;
    logic [7:0]  o_reply_inverse;
    logic        o_block_led;
    logic        o_red_led;
    logic        o_green_led;
    logic        o_beeper;
    logic        o_int_drive_low;

    shutter_panel_controller_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_command_byte   (i_command_byte),
        .i_key_level      (i_key_level),
        .i_switch_raw     (i_switch_raw),
        .i_int_line_level (i_int_line_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_reply       (o_is_reply),
        .o_reply          (o_reply),
        .o_reply_inverse  (o_reply_inverse),
        .o_block_led      (o_block_led),
        .o_red_led        (o_red_led),
        .o_green_led      (o_green_led),
        .o_beeper         (o_beeper),
        .o_int_drive_low  (o_int_drive_low),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted panel state and our copy of the configuration registers.
    // ------------------------------------------------------------------------
    logic [7:0]  cfg_debounce;
    logic [15:0] cfg_slow_blink;
    logic [15:0] cfg_fast_blink;
    logic [7:0]  cfg_beep_step;

    logic        flag_block_evt;
    logic        flag_switch_evt;
    logic        flag_beep_on;
    logic        flag_red;
    logic        flag_green;
    logic [1:0]  led_mode;
    logic        block_sw_on;
    logic [7:0]  reported_sw;
    logic        key_stable;
    logic [7:0]  key_count;
    logic        key_released;
    logic [7:0]  sw_stable;
    logic [7:0]  sw_count;
    logic [15:0] blink_count;
    logic [7:0]  beep_count;
    logic [15:0] beep_bits;
    logic        block_led_lvl;
    logic        beeper_lvl;

    // Bookkeeping shared by the processes below.
    t_beat   beats_to_send[$];
    t_result status_due[$];
    int      queued_cnt     = 0;
    int      accepted_cnt   = 0;
    int      results_seen   = 0;
    int      error_count    = 0;
    int      cycle_count    = 0;
    int      tick_cnt       = 0;
    int      command_cnt    = 0;
    int      release_cnt    = 0;
    int      sw_change_cnt  = 0;
    int      idle_pct       = 6;
    bit      in_taken       = 1'b0;

    // Generator state: the raw key, switch and line levels persist between
    // beats so that the debouncers see runs of steady input.
    logic        gen_key      = 1'b1;
    logic [7:0]  gen_sw       = 8'd0;
    logic        gen_line     = 1'b1;
    int          gen_key_run  = 0;
    int          gen_sw_run   = 0;

    task automatic panel_reset();
        cfg_debounce    = spc_pkg::DEBOUNCE_RST;
        cfg_slow_blink  = spc_pkg::SLOW_BLINK_RST;
        cfg_fast_blink  = spc_pkg::FAST_BLINK_RST;
        cfg_beep_step   = spc_pkg::BEEP_STEP_RST;
        flag_block_evt  = 1'b0;
        flag_switch_evt = 1'b0;
        flag_beep_on    = 1'b0;
        flag_red        = 1'b0;
        flag_green      = 1'b0;
        led_mode        = spc_pkg::MODE_OFF;
        block_sw_on     = 1'b0;
        reported_sw     = 8'd0;
        key_stable      = 1'b0;
        key_count       = spc_pkg::DEBOUNCE_RST;
        key_released    = 1'b0;
        sw_stable       = 8'd0;
        sw_count        = spc_pkg::DEBOUNCE_RST;
        blink_count     = 16'd0;
        beep_count      = 8'd0;
        beep_bits       = 16'd0;
        block_led_lvl   = 1'b0;
        beeper_lvl      = 1'b0;
    endtask

    // Applies one accepted beat to the predicted state and returns the
    // result beat that it must produce.
    function automatic t_result panel_apply(t_beat b);
        t_result    res;
        logic [7:0] r;
        logic [3:0] data;
        logic       pressed;
        logic       up;
        logic       dn;
        logic       sel_ok;

        r    = spc_pkg::REPLY_ERR;
        data = b.cmd_byte[3:0];
        up   = 1'b0;
        dn   = 1'b0;
        sel_ok = 1'b1;

        if (b.opcode == OP_COMMAND) begin
            // Even parity: bit 7 must equal the XOR of bits 6:0.
            if (b.cmd_byte[7] == ^b.cmd_byte[6:0]) begin
                case (spc_pkg::t_cmd'(b.cmd_byte[6:4]))
                    spc_pkg::CMD_LOAD_BEEP: begin
                        beep_bits = {12'd0, data};
                        r = spc_pkg::REPLY_OK;
                    end
                    spc_pkg::CMD_BLOCK_MODE: begin
                        led_mode = data[1:0];
                        r = spc_pkg::REPLY_OK;
                    end
                    spc_pkg::CMD_QUERY_SW: begin
                        case (data)
                            4'd1: begin up = reported_sw[4]; dn = reported_sw[3]; end
                            4'd2: begin up = reported_sw[5]; dn = reported_sw[2]; end
                            4'd3: begin up = reported_sw[6]; dn = reported_sw[1]; end
                            4'd4: begin up = reported_sw[0]; dn = reported_sw[7]; end
                            default: sel_ok = 1'b0;
                        endcase
                        if (!sel_ok) r = spc_pkg::REPLY_ERR;
                        else if (up) r = spc_pkg::REPLY_UP;
                        else if (dn) r = spc_pkg::REPLY_DOWN;
                        else r = spc_pkg::REPLY_NEITHER;
                    end
                    spc_pkg::CMD_INTERRUPT: begin
                        if (data != 4'd0) begin
                            flag_block_evt = 1'b1;
                        end else begin
                            flag_block_evt  = 1'b0;
                            flag_switch_evt = 1'b0;
                        end
                        r = spc_pkg::REPLY_OK;
                    end
                    spc_pkg::CMD_BLOCK_SW: begin
                        r = block_sw_on ? spc_pkg::REPLY_SW_ON : spc_pkg::REPLY_SW_OFF;
                        if (data == spc_pkg::BSW_DATA_CLEAR) block_sw_on = 1'b0;
                        else if (data == spc_pkg::BSW_DATA_SET) block_sw_on = 1'b1;
                    end
                    default: r = spc_pkg::REPLY_ERR;
                endcase
            end
        end else begin
            // Key debounce; the pin is active low.
            pressed = ~b.key_level;
            if (pressed != key_stable) begin
                key_count = key_count - 8'd1;
                if (key_count == 8'd0) begin
                    key_count  = cfg_debounce;
                    key_stable = pressed;
                    if (!pressed) key_released = 1'b1;
                end
            end else begin
                key_count = cfg_debounce;
            end

            if (b.switch_raw != sw_stable) begin
                sw_count = sw_count - 8'd1;
                if (sw_count == 8'd0) begin
                    sw_count  = cfg_debounce;
                    sw_stable = b.switch_raw;
                end
            end else begin
                sw_count = cfg_debounce;
            end

            // Status update: a key release toggles the block switch.
            if (key_released) begin
                key_released   = 1'b0;
                flag_block_evt = 1'b1;
                block_sw_on    = ~block_sw_on;
                release_cnt++;
            end
            if (sw_stable != reported_sw) begin
                reported_sw     = sw_stable;
                flag_switch_evt = 1'b1;
                sw_change_cnt++;
            end
            flag_red   = ~b.line_level;
            flag_green = ~(flag_block_evt | flag_switch_evt);

            if (led_mode == spc_pkg::MODE_OFF) begin
                block_led_lvl = 1'b0;
            end else if (led_mode == spc_pkg::MODE_ON) begin
                block_led_lvl = 1'b1;
            end else begin
                if (blink_count != 16'd0) blink_count = blink_count - 16'd1;
                if (blink_count == 16'd0) begin
                    block_led_lvl = ~block_led_lvl;
                    blink_count = (led_mode == spc_pkg::MODE_SLOW) ? cfg_slow_blink
                                                                   : cfg_fast_blink;
                end
            end

            // The pattern shifts out one bit per step; a set bit toggles the
            // speaker on odd counts of the step counter.
            if (beep_bits != 16'd0 || flag_beep_on) begin
                if (beep_count != 8'd0) beep_count = beep_count - 8'd1;
                if (beep_count == 8'd0) begin
                    if (beep_bits[0]) begin
                        flag_beep_on = 1'b1;
                    end else begin
                        flag_beep_on = 1'b0;
                        beeper_lvl   = 1'b0;
                    end
                    beep_bits  = beep_bits >> 1;
                    beep_count = cfg_beep_step;
                end
                if (beep_count[0] && flag_beep_on) beeper_lvl = ~beeper_lvl;
            end
        end

        res.is_reply  = b.opcode;
        res.reply     = r;
        res.reply_inv = (b.opcode == OP_COMMAND) ? ~r : 8'd0;
        res.block_led = block_led_lvl;
        res.red_led   = flag_red;
        res.green_led = flag_green;
        res.beeper    = beeper_lvl;
        res.int_low   = flag_block_evt | flag_switch_evt;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] encode_command(spc_pkg::t_cmd code, logic [3:0] data,
                                                  bit bad_parity);
        logic [7:0] b;
        b    = {1'b0, code, data};
        b[7] = (^b[6:0]) ^ bad_parity;
        return b;
    endfunction

    task automatic send(t_beat b);
        beats_to_send.push_back(b);
        queued_cnt++;
    endtask

    task automatic push_tick(logic key, logic [7:0] sw, logic line);
        t_beat b;
        b.opcode     = OP_TICK;
        b.cmd_byte   = 8'($urandom_range(0, 255));
        b.key_level  = key;
        b.switch_raw = sw;
        b.line_level = line;
        send(b);
    endtask

    task automatic push_cmd(spc_pkg::t_cmd code, logic [3:0] data, bit bad_parity);
        t_beat b;
        b.opcode     = OP_COMMAND;
        b.cmd_byte   = encode_command(code, data, bad_parity);
        b.key_level  = 1'($urandom_range(0, 1));
        b.switch_raw = 8'($urandom_range(0, 255));
        b.line_level = 1'($urandom_range(0, 1));
        send(b);
    endtask

    function automatic int run_length();
        return $urandom_range(1, 2 * int'(cfg_debounce) + 2);
    endfunction

    // Mostly ticks with steady runs of input, some shorter and some longer
    // than the debounce count; the rest are commands, a few of them broken.
    function automatic t_beat random_beat();
        t_beat         b;
        spc_pkg::t_cmd code;
        logic [3:0]    data;

        if ($urandom_range(0, 99) < 82) begin
            if (gen_key_run == 0) begin
                gen_key     = ~gen_key;
                gen_key_run = run_length();
            end
            if (gen_sw_run == 0) begin
                if ($urandom_range(0, 1) == 0) gen_sw = 8'($urandom_range(0, 255));
                else gen_sw[$urandom_range(0, 7)] = ~gen_sw[$urandom_range(0, 7)];
                gen_sw_run = run_length();
            end
            gen_key_run--;
            gen_sw_run--;
            if ($urandom_range(0, 19) == 0) gen_line = ~gen_line;
            b.opcode   = OP_TICK;
            b.cmd_byte = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 11))
                0, 1:    code = spc_pkg::CMD_LOAD_BEEP;
                2, 3:    code = spc_pkg::CMD_BLOCK_MODE;
                4, 5, 6: code = spc_pkg::CMD_QUERY_SW;
                7, 8:    code = spc_pkg::CMD_INTERRUPT;
                9, 10:   code = spc_pkg::CMD_BLOCK_SW;
                default: code = spc_pkg::t_cmd'($urandom_range(0, 7));
            endcase
            data = 4'($urandom_range(0, 15));
            if (code == spc_pkg::CMD_QUERY_SW && $urandom_range(0, 3) != 0)
                data = 4'($urandom_range(1, 4));
            if (code == spc_pkg::CMD_BLOCK_SW && $urandom_range(0, 3) != 0)
                data = $urandom_range(0, 1) ? spc_pkg::BSW_DATA_SET
                                            : spc_pkg::BSW_DATA_CLEAR;
            if (code == spc_pkg::CMD_INTERRUPT && $urandom_range(0, 1) == 0)
                data = 4'd0;
            b.opcode   = OP_COMMAND;
            b.cmd_byte = encode_command(code, data, $urandom_range(0, 99) < 10);
        end
        b.key_level  = gen_key;
        b.switch_raw = gen_sw;
        b.line_level = gen_line;
        return b;
    endfunction

    // Register writes happen only while the block is idle. Consecutive writes
    // keep the enable high; the caller lowers it afterwards.
    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            spc_pkg::REG_DEBOUNCE:   cfg_debounce   = value[7:0];
            spc_pkg::REG_SLOW_BLINK: cfg_slow_blink = value;
            spc_pkg::REG_FAST_BLINK: cfg_fast_blink = value;
            spc_pkg::REG_BEEP_STEP:  cfg_beep_step  = value[7:0];
            default: ;
        endcase
    endtask

    // The sender holds back until every beat is in and every result is out.
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || status_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic report(string msg);
        if (error_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report($sformatf("result %0d: %s is %0h, expected %0h",
                             results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Input driver. A beat that is offered stays put until it is taken; idle
    // bursts start only between beats.
    // ------------------------------------------------------------------------
    int send_gap = 0;

    always @(negedge i_clk) begin : driver
        t_beat b;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // Stalled: the beat and its payload hold.
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (beats_to_send.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(0, 16);
            i_in_valid <= 1'b0;
        end else begin
            b = beats_to_send.pop_front();
            i_opcode         <= b.opcode;
            i_command_byte   <= b.cmd_byte;
            i_key_level      <= b.key_level;
            i_switch_raw     <= b.switch_raw;
            i_int_line_level <= b.line_level;
            i_in_valid       <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Besides the random stall bursts it holds off once for
    // a long stretch, so that both registers of the block fill and its input
    // stalls while the driver keeps offering beats.
    // ------------------------------------------------------------------------
    int  stall_gap      = 0;
    int  hold_left      = 0;
    bit  long_hold_done = 1'b0;

    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap--;
            i_out_stall <= 1'b1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_gap = $urandom_range(0, 16);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge: an accepted input
    // beat is run through the prediction at once, and an accepted result beat
    // is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_beat   b;
        t_result want;
        cycle_count++;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                b.opcode     = i_opcode;
                b.cmd_byte   = i_command_byte;
                b.key_level  = i_key_level;
                b.switch_raw = i_switch_raw;
                b.line_level = i_int_line_level;
                status_due.push_back(panel_apply(b));
                if (b.opcode == OP_COMMAND) command_cnt++;
                else tick_cnt++;
                accepted_cnt++;
                in_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing expected",
                                     results_seen));
                end else begin
                    want = status_due.pop_front();
                    check_field("is_reply", 8'(o_is_reply), 8'(want.is_reply));
                    check_field("reply", o_reply, want.reply);
                    check_field("reply_inverse", o_reply_inverse, want.reply_inv);
                    check_field("block_led", 8'(o_block_led), 8'(want.block_led));
                    check_field("red_led", 8'(o_red_led), 8'(want.red_led));
                    check_field("green_led", 8'(o_green_led), 8'(want.green_led));
                    check_field("beeper", 8'(o_beeper), 8'(want.beeper));
                    check_field("int_drive_low", 8'(o_int_drive_low), 8'(want.int_low));
                end
                results_seen++;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, status_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence: a directed opening at the reset settings, then phases of
    // random beats, each under its own register setting. Settings change only
    // after the block has drained.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  dbc;
        logic [15:0] slow;
        logic [15:0] fast;
        logic [7:0]  step;
        int          n_beats;

        panel_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: field extremes, every command code, the parity
        // error, unknown codes, and switch selects out of range.
        push_tick(1'b1, 8'h00, 1'b1);
        push_tick(1'b0, 8'hFF, 1'b0);
        push_tick(1'b1, 8'hA5, 1'b1);
        push_cmd(spc_pkg::CMD_NOP, 4'h0, 1'b0);
        push_cmd(spc_pkg::CMD_LOAD_BEEP, 4'hF, 1'b0);
        push_cmd(spc_pkg::CMD_LOAD_BEEP, 4'h0, 1'b0);
        push_cmd(spc_pkg::CMD_BLOCK_MODE, 4'hF, 1'b0);
        push_cmd(spc_pkg::CMD_BLOCK_MODE, 4'h0, 1'b0);
        push_cmd(spc_pkg::CMD_QUERY_SW, 4'd1, 1'b0);
        push_cmd(spc_pkg::CMD_QUERY_SW, 4'd2, 1'b0);
        push_cmd(spc_pkg::CMD_QUERY_SW, 4'd3, 1'b0);
        push_cmd(spc_pkg::CMD_QUERY_SW, 4'd4, 1'b0);
        push_cmd(spc_pkg::CMD_QUERY_SW, 4'd0, 1'b0);
        push_cmd(spc_pkg::CMD_QUERY_SW, 4'd5, 1'b0);
        push_cmd(spc_pkg::CMD_QUERY_SW, 4'hF, 1'b0);
        push_cmd(spc_pkg::CMD_INTERRUPT, 4'hF, 1'b0);
        push_cmd(spc_pkg::CMD_INTERRUPT, 4'h0, 1'b0);
        push_cmd(spc_pkg::CMD_BLOCK_SW, spc_pkg::BSW_DATA_SET, 1'b0);
        push_cmd(spc_pkg::CMD_BLOCK_SW, 4'h0, 1'b0);
        push_cmd(spc_pkg::CMD_BLOCK_SW, spc_pkg::BSW_DATA_CLEAR, 1'b0);
        push_cmd(spc_pkg::CMD_SPARE6, 4'h0, 1'b0);
        push_cmd(spc_pkg::CMD_SPARE7, 4'hF, 1'b0);
        push_cmd(spc_pkg::CMD_LOAD_BEEP, 4'h1, 1'b1);
        push_cmd(spc_pkg::CMD_QUERY_SW, 4'd1, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    dbc = 8'd1;   slow = 16'd1;     fast = 16'd1;     step = 8'd1;
                    n_beats = 180; idle_pct = 0;
                end
                1: begin
                    dbc = 8'd2;   slow = 16'd7;     fast = 16'd3;     step = 8'd2;
                    n_beats = 180; idle_pct = 10;
                end
                2: begin
                    dbc = 8'd255; slow = 16'd65535; fast = 16'd65535; step = 8'd255;
                    n_beats = 160; idle_pct = 5;
                end
                PHASES - 1: begin
                    // Closing phase runs with no idling on either side.
                    dbc = 8'd3;   slow = 16'd4;     fast = 16'd2;     step = 8'd3;
                    n_beats = 150; idle_pct = 0;
                end
                default: begin
                    dbc  = 8'($urandom_range(1, 5));
                    slow = 16'($urandom_range(1, 12));
                    fast = 16'($urandom_range(1, 6));
                    step = 8'($urandom_range(1, 6));
                    n_beats = 170;
                    case ($urandom_range(0, 2))
                        0:       idle_pct = 0;
                        1:       idle_pct = 8;
                        default: idle_pct = 25;
                    endcase
                end
            endcase
            // The 8-bit registers only keep the low byte of the write data.
            write_reg(spc_pkg::REG_DEBOUNCE, {8'($urandom_range(0, 255)), dbc});
            write_reg(spc_pkg::REG_SLOW_BLINK, slow);
            write_reg(spc_pkg::REG_FAST_BLINK, fast);
            write_reg(spc_pkg::REG_BEEP_STEP, {8'($urandom_range(0, 255)), step});
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            repeat (n_beats) send(random_beat());
        end
        wait_drained();

        $display("Covered %0d beats (%0d ticks, %0d commands) under %0d register settings.",
                 accepted_cnt, tick_cnt, command_cnt, PHASES + 1);
        $display("Debounce passed %0d key releases and %0d switch changes; %0d results checked.",
                 release_cnt, sw_change_cnt, results_seen);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/spc_pkg.sv
hw/rtl/spc_cmd.sv
hw/rtl/spc_core.sv
hw/rtl/shutter_panel_controller_top.sv
sim/tb.sv
